// ===== sv/vldr_pkg.sv =====
// Shared types and constants for the voltage-limited duty ramp core.
// Used by voltage_limited_duty_ramp_core and vldr_checker; no dependencies.
package vldr_pkg;

    localparam int PULSE_W  = 16;
    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 10;
    localparam int TARGET_W = 11;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register index codes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRAKE_PULSE_LIMIT = 2'd0,
        CFG_VOLTAGE_THRESHOLD = 2'd1,
        CFG_DUTY_CEILING      = 2'd2,
        CFG_STARTUP_DUTY      = 2'd3
    } cfg_index_t;

    localparam logic [PULSE_W-1:0]  BRAKE_PULSE_LIMIT_RST = 16'd55000;
    localparam logic [SAMPLE_W-1:0] VOLTAGE_THRESHOLD_RST = 12'd2460;
    localparam logic [DUTY_W-1:0]   DUTY_CEILING_RST      = 10'd703;
    localparam logic [DUTY_W-1:0]   STARTUP_DUTY_RST      = 10'd9;

    // Full-scale pulse; the command is (PULSE_FULL - pulse) / 48
    localparam logic [PULSE_W-1:0] PULSE_FULL = 16'hFFFF;

    // Divide by 48 = shift by 4, then divide by 3 as multiply by 2731 / 2^13.
    // Exact for every 12-bit quotient input.
    localparam int DIV3_SHIFT = 13;
    localparam logic [11:0] DIV3_RECIP = 12'd2731;

    // Largest target reachable: 65535 / 48
    localparam logic [TARGET_W-1:0] TARGET_MAX = 11'd1365;

    // Output sideband bits
    localparam int USER_BRAKE_BIT = 0;
    localparam int USER_KICK_BIT  = 1;

endpackage

// ===== sv/voltage_limited_duty_ramp_core.sv =====
// Voltage-limited duty ramp core: brake, startup kick, target ramp and
// voltage-gated duty rise/fall, one result per control tick. Uses vldr_pkg.
//
// Path: a tick is captured in the input register and moves into the output
//   register when that register is free or being emptied by the consumer.
// Throughput: one tick per clock while the consumer accepts results; the
//   state update between the input and result registers sets that rate.
// Reset (rst_n low, asynchronous): configuration returns to its defaults,
//   duty and target clear, the bridge starts in brake, both stages empty.
module voltage_limited_duty_ramp_core (
    input  logic        clk,
    input  logic        rst_n,
    // Tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] servo_pulse, [27:16] voltage_sample, rest zero
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [9:0] duty, [20:10] target_level, rest zero
    output logic [1:0]  m_tuser,    // [0] brake, [1] startup_kick
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [vldr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vldr_pkg::CFG_W-1:0]     cfg_data
);
    import vldr_pkg::*;

    // Configuration registers
    logic [PULSE_W-1:0]  brake_pulse_limit_reg;
    logic [SAMPLE_W-1:0] voltage_threshold_reg;
    logic [DUTY_W-1:0]   duty_ceiling_reg;
    logic [DUTY_W-1:0]   startup_duty_reg;

    // Input stage
    logic                in_valid_reg;
    logic [PULSE_W-1:0]  pulse_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Controller state
    logic [DUTY_W-1:0]   working_duty_reg, working_duty_next;
    logic [DUTY_W-1:0]   driven_duty_reg,  driven_duty_next;
    logic [TARGET_W-1:0] target_duty_reg,  target_duty_next;
    logic                braking_reg,      braking_next;
    logic                kick_next;

    // Output stage
    logic                out_valid_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [TARGET_W-1:0] out_target_reg;
    logic                out_brake_reg;
    logic                out_kick_reg;

    logic in_fire;
    logic advance;

    // Move the held tick into the result register when that register is free
    // or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    // Configuration writes; an index outside the list cannot occur with a
    // two-bit index, the default arm keeps the case complete.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_pulse_limit_reg <= BRAKE_PULSE_LIMIT_RST;
            voltage_threshold_reg <= VOLTAGE_THRESHOLD_RST;
            duty_ceiling_reg      <= DUTY_CEILING_RST;
            startup_duty_reg      <= STARTUP_DUTY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BRAKE_PULSE_LIMIT: brake_pulse_limit_reg <= cfg_data[PULSE_W-1:0];
                CFG_VOLTAGE_THRESHOLD: voltage_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_DUTY_CEILING:      duty_ceiling_reg      <= cfg_data[DUTY_W-1:0];
                CFG_STARTUP_DUTY:      startup_duty_reg      <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: capture a tick whenever the stage is free or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pulse_reg  <= s_tdata[PULSE_W-1:0];
            sample_reg <= s_tdata[PULSE_W+SAMPLE_W-1:PULSE_W];
        end
    end

    // Command = (65535 - pulse) / 48, taken as ((x >> 4) * 2731) >> 13.
    logic [PULSE_W-1:0]  headroom;
    logic [11:0]         headroom_div16;
    logic [23:0]         div3_product;
    logic [TARGET_W-1:0] command;

    assign headroom       = PULSE_FULL - pulse_reg;
    assign headroom_div16 = headroom[PULSE_W-1:4];
    assign div3_product   = 24'(headroom_div16) * 24'(DIV3_RECIP);
    assign command        = div3_product[DIV3_SHIFT+TARGET_W-1:DIV3_SHIFT];

    // One control tick
    logic                brake_tick;
    logic [DUTY_W-1:0]   driven_base;
    logic [DUTY_W-1:0]   clamped_duty;
    logic                voltage_high;

    always_comb
    begin
        brake_tick        = pulse_reg > brake_pulse_limit_reg;
        voltage_high      = sample_reg > voltage_threshold_reg;
        working_duty_next = working_duty_reg;
        driven_duty_next  = driven_duty_reg;
        target_duty_next  = target_duty_reg;
        braking_next      = braking_reg;
        kick_next         = 1'b0;
        driven_base       = driven_duty_reg;
        clamped_duty      = working_duty_reg;

        if (brake_tick)
        begin
            // Brake: drop the working duty, hold the driven duty and target.
            working_duty_next = '0;
            braking_next      = 1'b1;
        end
        else
        begin
            // Leaving brake: kick the motor and drive the startup duty.
            braking_next = 1'b0;
            kick_next    = braking_reg;
            if (braking_reg)
            begin
                driven_base = startup_duty_reg;
            end

            // Step the target up by one while below the command, else down by one, floor at zero.
            if (command > target_duty_reg)
            begin
                target_duty_next = target_duty_reg + 1'b1;
            end
            else if (target_duty_reg != '0)
            begin
                target_duty_next = target_duty_reg - 1'b1;
            end

            // Clamp to a nonzero target only.
            if (target_duty_next != '0
                && {1'b0, working_duty_reg} > target_duty_next)
            begin
                clamped_duty = target_duty_next[DUTY_W-1:0];
            end

            working_duty_next = clamped_duty;
            driven_duty_next  = driven_base;

            if (voltage_high)
            begin
                if (clamped_duty < duty_ceiling_reg
                    && {1'b0, clamped_duty} < target_duty_next)
                begin
                    working_duty_next = clamped_duty + 1'b1;
                    driven_duty_next  = clamped_duty + 1'b1;
                end
            end
            else if (clamped_duty > DUTY_W'(1))
            begin
                working_duty_next = clamped_duty - DUTY_W'(2);
                driven_duty_next  = clamped_duty - DUTY_W'(2);
            end
        end
    end

    // Commit state as the tick moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            working_duty_reg <= '0;
            driven_duty_reg  <= '0;
            target_duty_reg  <= '0;
            braking_reg      <= 1'b1;
        end
        else if (advance)
        begin
            working_duty_reg <= working_duty_next;
            driven_duty_reg  <= driven_duty_next;
            target_duty_reg  <= target_duty_next;
            braking_reg      <= braking_next;
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_duty_reg   <= driven_duty_next;
            out_target_reg <= target_duty_next;
            out_brake_reg  <= braking_next;
            out_kick_reg   <= kick_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_target_reg, out_duty_reg};
    assign m_tuser[USER_BRAKE_BIT] = out_brake_reg;
    assign m_tuser[USER_KICK_BIT]  = out_kick_reg;

endmodule

// ===== sv/vldr_checker.sv =====
// Port-level assertions for voltage_limited_duty_ramp_core, bound to the top.
// Uses vldr_pkg for field widths and sideband bit positions.
module vldr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic                          cfg_we,
    input logic [vldr_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [vldr_pkg::CFG_W-1:0]     cfg_data
);
    import vldr_pkg::*;

    logic                out_fire;
    logic [TARGET_W-1:0] target_now;
    logic [DUTY_W-1:0]   duty_now;

    assign out_fire   = m_tvalid && m_tready;
    assign target_now = m_tdata[DUTY_W+TARGET_W-1:DUTY_W];
    assign duty_now   = m_tdata[DUTY_W-1:0];

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A kick only happens on a tick that runs, never while braking.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[USER_KICK_BIT] && m_tuser[USER_BRAKE_BIT]))
        else $error("kick reported together with brake");

    // The target never exceeds the largest command.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> target_now <= TARGET_MAX)
        else $error("target above full-scale command");

    // Successive results move the target by at most one step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && $past(out_fire) |->
            (target_now == $past(target_now))
            || (target_now == $past(target_now) + 11'd1)
            || (target_now + 11'd1 == $past(target_now)))
        else $error("target stepped by more than one");

    // A brake tick keeps the driven duty of the previous result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && $past(out_fire) && m_tuser[USER_BRAKE_BIT] |->
            duty_now == $past(duty_now))
        else $error("duty changed on a brake tick");

endmodule

bind voltage_limited_duty_ramp_core vldr_checker u_vldr_checker (.*);
